// ===== hw/rtl/point_projection_residual_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the projection residual block
// Concurrent checks that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef POINT_PROJECTION_RESIDUAL_MACROS_SVH
`define POINT_PROJECTION_RESIDUAL_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PPR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define PPR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PPR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define PPR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/ppr_pkg.sv =====
// ----------------------------------------------------------------------------
// ppr_pkg
// Shared types, stage indices and fixed-point helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package ppr_pkg;

    typedef enum logic [2:0] {
        REG_FOCAL   = 3'd0,
        REG_CENTER  = 3'd1,
        REG_RADIAL  = 3'd2,
        REG_TANG    = 3'd3,
        REG_ROT_XY  = 3'd4,
        REG_ROT_ZW  = 3'd5,
        REG_SHIFT_XY = 3'd6,
        REG_SHIFT_Z = 3'd7
    } reg_idx_t;

    localparam int unsigned NUM_REGS = 8;
    localparam logic [63:0] ROT_ZW_RESET = 64'h0000_0000_4000_0000;

    localparam logic signed [63:0] ONE_Q28 = 64'sd268435456;
    localparam logic signed [63:0] ONE_Q30 = 64'sd1073741824;

    // pipeline stage indices
    localparam int unsigned ST_ROTP  = 0;
    localparam int unsigned ST_MAT   = 1;
    localparam int unsigned ST_PROD  = 2;
    localparam int unsigned ST_CAM   = 3;
    localparam int unsigned ST_MAG   = 4;
    localparam int unsigned ST_DIV0  = 5;
    localparam int unsigned DIV_BITS = 32;
    localparam int unsigned ST_NORM  = ST_DIV0 + DIV_BITS + 1;
    localparam int unsigned ST_SQ    = ST_NORM + 1;
    localparam int unsigned ST_RSQ   = ST_NORM + 2;
    localparam int unsigned ST_RPOW  = ST_NORM + 3;
    localparam int unsigned ST_RSUM  = ST_NORM + 4;
    localparam int unsigned ST_RAD   = ST_NORM + 5;
    localparam int unsigned ST_SCALE = ST_NORM + 6;
    localparam int unsigned ST_DIST  = ST_NORM + 7;
    localparam int unsigned ST_FOCAL = ST_NORM + 8;
    localparam int unsigned ST_RES   = ST_NORM + 9;
    localparam int unsigned ST_PROJ  = ST_NORM + 10;
    localparam int unsigned ST_OUT   = ST_NORM + 11;
    localparam int unsigned NUM_ST   = ST_OUT + 1;

    // per-item fields carried alongside the arithmetic
    typedef struct packed {
        logic signed [31:0] seen_u;
        logic signed [31:0] seen_v;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic               bad;
    } side_t;

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (v < -64'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    // exact product, round half up, arithmetic shift
    function automatic logic signed [63:0] mulsh(input logic signed [31:0] a,
                                                 input logic signed [31:0] b,
                                                 input int unsigned s);
        logic signed [63:0] p;
        p = a * b;
        return (p + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/point_projection_residual.sv =====
// The pipeline has ppr_pkg::NUM_ST stages from input beat to result beat.
// Throughput: one point per cycle while out_ready does not stall the pipe; the 32
// one-bit-per-stage divider stages set the depth, every multiplier stage is fully pipelined.
// Stalls hold each full stage; empty stages still fill, so bubbles close up.
// Reset (rst_n low, asynchronous) empties the pipeline and returns the
// registers to identity pose and zero intrinsics; no clearing pass.
// ----------------------------------------------------------------------------
// point_projection_residual
// Pinhole projection with radial/tangential distortion and pixel residual,
// optionally projected onto the normal of an edge direction.
// ----------------------------------------------------------------------------
`default_nettype none

`include "point_projection_residual_macros.svh"

module point_projection_residual (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // APB-style register port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [5:0]         paddr,
    input  wire logic [63:0]        pwdata,
    output logic      [63:0]        prdata,
    output logic                    pready,
    // point channel
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [31:0] point_x,
    input  wire logic signed [31:0] point_y,
    input  wire logic signed [31:0] point_z,
    input  wire logic signed [31:0] seen_u,
    input  wire logic signed [31:0] seen_v,
    input  wire logic signed [31:0] edge_dir_x,
    input  wire logic signed [31:0] edge_dir_y,
    // residual channel
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      resid_u,
    output logic signed [31:0]      resid_v,
    output logic                    depth_bad
);

    localparam int unsigned NST = ppr_pkg::NUM_ST;

    // ------------------------------------------------------------------
    // Register file. The user must let writes arrive only while the pipe is empty;
    // the block itself does not enforce it. The stages read the live values directly.
    // ------------------------------------------------------------------
    logic [63:0] cfg_reg [ppr_pkg::NUM_REGS];
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = cfg_reg[paddr[5:3]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ppr_pkg::NUM_REGS; i++)
                cfg_reg[i] <= 64'd0;
            cfg_reg[ppr_pkg::REG_ROT_ZW] <= ppr_pkg::ROT_ZW_RESET;
        end
        else if (cfg_wr)
        begin
            if (ppr_pkg::reg_idx_t'(paddr[5:3]) == ppr_pkg::REG_SHIFT_Z)
                cfg_reg[paddr[5:3]] <= {32'd0, pwdata[31:0]};
            else
                cfg_reg[paddr[5:3]] <= pwdata;
        end
    end

    logic signed [31:0] fx, fy, cx, cy, k1, k2, p1, p2;
    logic signed [31:0] qx, qy, qz, qw, tx, ty, tz;

    assign fx = $signed(cfg_reg[ppr_pkg::REG_FOCAL][63:32]);
    assign fy = $signed(cfg_reg[ppr_pkg::REG_FOCAL][31:0]);
    assign cx = $signed(cfg_reg[ppr_pkg::REG_CENTER][63:32]);
    assign cy = $signed(cfg_reg[ppr_pkg::REG_CENTER][31:0]);
    assign k1 = $signed(cfg_reg[ppr_pkg::REG_RADIAL][63:32]);
    assign k2 = $signed(cfg_reg[ppr_pkg::REG_RADIAL][31:0]);
    assign p1 = $signed(cfg_reg[ppr_pkg::REG_TANG][63:32]);
    assign p2 = $signed(cfg_reg[ppr_pkg::REG_TANG][31:0]);
    assign qx = $signed(cfg_reg[ppr_pkg::REG_ROT_XY][63:32]);
    assign qy = $signed(cfg_reg[ppr_pkg::REG_ROT_XY][31:0]);
    assign qz = $signed(cfg_reg[ppr_pkg::REG_ROT_ZW][63:32]);
    assign qw = $signed(cfg_reg[ppr_pkg::REG_ROT_ZW][31:0]);
    assign tx = $signed(cfg_reg[ppr_pkg::REG_SHIFT_XY][63:32]);
    assign ty = $signed(cfg_reg[ppr_pkg::REG_SHIFT_XY][31:0]);
    assign tz = $signed(cfg_reg[ppr_pkg::REG_SHIFT_Z][31:0]);

    // ------------------------------------------------------------------
    // Flow control: a stage loads when it is empty or its successor loads.
    // ------------------------------------------------------------------
    logic [NST-1:0] v_reg;
    logic [NST-1:0] en;

    assign en[NST-1] = !v_reg[NST-1] || out_ready;
    for (genvar gi = 0; gi < NST - 1; gi++)
    begin : g_en
        assign en[gi] = !v_reg[gi] || en[gi+1];
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (en[0])
                v_reg[0] <= in_valid;
            for (int i = 1; i < NST; i++)
                if (en[i])
                    v_reg[i] <= v_reg[i-1];
        end
    end

    // ------------------------------------------------------------------
    // Stage: quaternion products (Q2.30 x Q2.30, scaled by 2)
    // ------------------------------------------------------------------
    logic signed [35:0] tq_reg [9];
    logic signed [31:0] pt_reg [3];
    ppr_pkg::side_t     sd_rotp_reg;

    always_ff @(posedge clk)
    begin
        if (en[ppr_pkg::ST_ROTP])
        begin
            tq_reg[0] <= 36'(ppr_pkg::mulsh(qx, qx, 29));
            tq_reg[1] <= 36'(ppr_pkg::mulsh(qy, qy, 29));
            tq_reg[2] <= 36'(ppr_pkg::mulsh(qz, qz, 29));
            tq_reg[3] <= 36'(ppr_pkg::mulsh(qx, qy, 29));
            tq_reg[4] <= 36'(ppr_pkg::mulsh(qx, qz, 29));
            tq_reg[5] <= 36'(ppr_pkg::mulsh(qy, qz, 29));
            tq_reg[6] <= 36'(ppr_pkg::mulsh(qw, qx, 29));
            tq_reg[7] <= 36'(ppr_pkg::mulsh(qw, qy, 29));
            tq_reg[8] <= 36'(ppr_pkg::mulsh(qw, qz, 29));
            pt_reg[0] <= point_x;
            pt_reg[1] <= point_y;
            pt_reg[2] <= point_z;
            sd_rotp_reg <= '{seen_u: seen_u, seen_v: seen_v, dir_x: edge_dir_x,
                             dir_y: edge_dir_y, bad: 1'b0};
        end
    end

    // ------------------------------------------------------------------
    // Stage: rotation matrix entries, saturated Q2.30
    // ------------------------------------------------------------------
    logic signed [31:0] m_reg [9];
    logic signed [31:0] pt_mat_reg [3];
    ppr_pkg::side_t     sd_mat_reg;

    always_ff @(posedge clk)
    begin
        if (en[ppr_pkg::ST_MAT])
        begin
            m_reg[0] <= ppr_pkg::clamp32(ppr_pkg::ONE_Q30 - (64'(tq_reg[1]) + 64'(tq_reg[2])));
            m_reg[1] <= ppr_pkg::clamp32(64'(tq_reg[3]) - 64'(tq_reg[8]));
            m_reg[2] <= ppr_pkg::clamp32(64'(tq_reg[4]) + 64'(tq_reg[7]));
            m_reg[3] <= ppr_pkg::clamp32(64'(tq_reg[3]) + 64'(tq_reg[8]));
            m_reg[4] <= ppr_pkg::clamp32(ppr_pkg::ONE_Q30 - (64'(tq_reg[0]) + 64'(tq_reg[2])));
            m_reg[5] <= ppr_pkg::clamp32(64'(tq_reg[5]) - 64'(tq_reg[6]));
            m_reg[6] <= ppr_pkg::clamp32(64'(tq_reg[4]) - 64'(tq_reg[7]));
            m_reg[7] <= ppr_pkg::clamp32(64'(tq_reg[5]) + 64'(tq_reg[6]));
            m_reg[8] <= ppr_pkg::clamp32(ppr_pkg::ONE_Q30 - (64'(tq_reg[0]) + 64'(tq_reg[1])));
            pt_mat_reg <= pt_reg;
            sd_mat_reg <= sd_rotp_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage: nine matrix-by-point products
    // ------------------------------------------------------------------
    logic signed [35:0] pm_reg [9];
    ppr_pkg::side_t     sd_prod_reg;

    always_ff @(posedge clk)
    begin
        if (en[ppr_pkg::ST_PROD])
        begin
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    pm_reg[3*r+c] <= 36'(ppr_pkg::mulsh(m_reg[3*r+c], pt_mat_reg[c], 30));
            sd_prod_reg <= sd_mat_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage: camera-frame point, exact (fits 36 bits signed)
    // ------------------------------------------------------------------
    logic signed [35:0] cam_reg [3];
    ppr_pkg::side_t     sd_cam_reg;

    always_ff @(posedge clk)
    begin
        if (en[ppr_pkg::ST_CAM])
        begin
            cam_reg[0] <= pm_reg[0] + pm_reg[1] + pm_reg[2] + 36'(tx);
            cam_reg[1] <= pm_reg[3] + pm_reg[4] + pm_reg[5] + 36'(ty);
            cam_reg[2] <= pm_reg[6] + pm_reg[7] + pm_reg[8] + 36'(tz);
            sd_cam_reg <= sd_prod_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage: magnitudes, signs and depth check for the divider
    // ------------------------------------------------------------------
    logic [34:0]    mag_a_reg, mag_b_reg, den_reg;
    logic           neg_a_reg, neg_b_reg;
    ppr_pkg::side_t sd_mag_reg;

    always_ff @(posedge clk)
    begin
        if (en[ppr_pkg::ST_MAG])
        begin
            neg_a_reg  <= cam_reg[0][35];
            neg_b_reg  <= cam_reg[1][35];
            mag_a_reg  <= cam_reg[0][35] ? 35'(-cam_reg[0]) : cam_reg[0][34:0];
            mag_b_reg  <= cam_reg[1][35] ? 35'(-cam_reg[1]) : cam_reg[1][34:0];
            den_reg    <= cam_reg[2][34:0];
            sd_mag_reg <= sd_cam_reg;
            sd_mag_reg.bad <= (cam_reg[2] <= 36'sd0);
        end
    end

    // ------------------------------------------------------------------
    // Divider: (mag << 28) / den, one quotient bit per stage.
    // Entry stage checks the upper word for overflow of 32 quotient bits.
    // ------------------------------------------------------------------
    logic [34:0]    ra_reg [ppr_pkg::DIV_BITS+1];
    logic [34:0]    rb_reg [ppr_pkg::DIV_BITS+1];
    logic [31:0]    qa_reg [ppr_pkg::DIV_BITS+1];
    logic [31:0]    qb_reg [ppr_pkg::DIV_BITS+1];
    logic [3:0]     la_reg [ppr_pkg::DIV_BITS+1];
    logic [3:0]     lb_reg [ppr_pkg::DIV_BITS+1];
    logic [34:0]    dv_reg [ppr_pkg::DIV_BITS+1];
    logic           oa_reg [ppr_pkg::DIV_BITS+1];
    logic           ob_reg [ppr_pkg::DIV_BITS+1];
    logic           sa_reg [ppr_pkg::DIV_BITS+1];
    logic           sb_reg [ppr_pkg::DIV_BITS+1];
    ppr_pkg::side_t sd_div_reg [ppr_pkg::DIV_BITS+1];

    always_ff @(posedge clk)
    begin
        if (en[ppr_pkg::ST_DIV0])
        begin
            ra_reg[0] <= {4'd0, mag_a_reg[34:4]};
            rb_reg[0] <= {4'd0, mag_b_reg[34:4]};
            oa_reg[0] <= ({4'd0, mag_a_reg[34:4]} >= den_reg);
            ob_reg[0] <= ({4'd0, mag_b_reg[34:4]} >= den_reg);
            la_reg[0] <= mag_a_reg[3:0];
            lb_reg[0] <= mag_b_reg[3:0];
            qa_reg[0] <= 32'd0;
            qb_reg[0] <= 32'd0;
            dv_reg[0] <= den_reg;
            sa_reg[0] <= neg_a_reg;
            sb_reg[0] <= neg_b_reg;
            sd_div_reg[0] <= sd_mag_reg;
        end
    end

    for (genvar gk = 1; gk <= ppr_pkg::DIV_BITS; gk++)
    begin : g_div
        localparam int unsigned BI = ppr_pkg::DIV_BITS - gk;
        logic        bit_a, bit_b;
        logic [35:0] trial_a, trial_b;
        logic        ge_a, ge_b;

        // only the top four dividend bits of the low word are non-zero
        if (BI >= 28)
        begin : g_lo
            assign bit_a = la_reg[gk-1][BI-28];
            assign bit_b = lb_reg[gk-1][BI-28];
        end
        else
        begin : g_zero
            assign bit_a = 1'b0;
            assign bit_b = 1'b0;
        end

        assign trial_a = {ra_reg[gk-1], bit_a};
        assign trial_b = {rb_reg[gk-1], bit_b};
        assign ge_a    = trial_a >= {1'b0, dv_reg[gk-1]};
        assign ge_b    = trial_b >= {1'b0, dv_reg[gk-1]};

        always_ff @(posedge clk)
        begin
            if (en[ppr_pkg::ST_DIV0+gk])
            begin
                ra_reg[gk] <= ge_a ? 35'(trial_a - {1'b0, dv_reg[gk-1]}) : trial_a[34:0];
                rb_reg[gk] <= ge_b ? 35'(trial_b - {1'b0, dv_reg[gk-1]}) : trial_b[34:0];
                qa_reg[gk] <= {qa_reg[gk-1][30:0], ge_a};
                qb_reg[gk] <= {qb_reg[gk-1][30:0], ge_b};
                la_reg[gk] <= la_reg[gk-1];
                lb_reg[gk] <= lb_reg[gk-1];
                dv_reg[gk] <= dv_reg[gk-1];
                oa_reg[gk] <= oa_reg[gk-1];
                ob_reg[gk] <= ob_reg[gk-1];
                sa_reg[gk] <= sa_reg[gk-1];
                sb_reg[gk] <= sb_reg[gk-1];
                sd_div_reg[gk] <= sd_div_reg[gk-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage: signed, saturated normalised coordinates (Q4.28)
    // ------------------------------------------------------------------
    localparam int unsigned DL = ppr_pkg::DIV_BITS;

    logic signed [31:0] na_next, nb_next;
    logic signed [31:0] na_reg, nb_reg;
    ppr_pkg::side_t     sd_norm_reg;

    always_comb
    begin
        if (!sa_reg[DL])
            na_next = (oa_reg[DL] || qa_reg[DL][31]) ? 32'sh7FFF_FFFF : $signed(qa_reg[DL]);
        else
            na_next = (oa_reg[DL] || (qa_reg[DL] > 32'h8000_0000)) ? 32'sh8000_0000
                    : $signed(-qa_reg[DL]);
        if (!sb_reg[DL])
            nb_next = (ob_reg[DL] || qb_reg[DL][31]) ? 32'sh7FFF_FFFF : $signed(qb_reg[DL]);
        else
            nb_next = (ob_reg[DL] || (qb_reg[DL] > 32'h8000_0000)) ? 32'sh8000_0000
                    : $signed(-qb_reg[DL]);
    end

    always_ff @(posedge clk)
    begin
        if (en[ppr_pkg::ST_NORM])
        begin
            na_reg <= na_next;
            nb_reg <= nb_next;
            sd_norm_reg <= sd_div_reg[DL];
        end
    end

    // ------------------------------------------------------------------
    // Stage: squares and cross term (Q8.24)
    // ------------------------------------------------------------------
    logic signed [31:0] aa_reg, bb_reg, ab_reg, na_sq_reg, nb_sq_reg;
    ppr_pkg::side_t     sd_sq_reg;

    always_ff @(posedge clk)
    begin
        if (en[ppr_pkg::ST_SQ])
        begin
            aa_reg <= ppr_pkg::clamp32(ppr_pkg::mulsh(na_reg, na_reg, 32));
            bb_reg <= ppr_pkg::clamp32(ppr_pkg::mulsh(nb_reg, nb_reg, 32));
            ab_reg <= ppr_pkg::clamp32(ppr_pkg::mulsh(na_reg, nb_reg, 32));
            na_sq_reg <= na_reg;
            nb_sq_reg <= nb_reg;
            sd_sq_reg <= sd_norm_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage: r = aa + bb
    // ------------------------------------------------------------------
    logic signed [31:0] rsq_reg, aa_r_reg, bb_r_reg, ab_r_reg, na_r_reg, nb_r_reg;
    ppr_pkg::side_t     sd_rsq_reg;

    always_ff @(posedge clk)
    begin
        if (en[ppr_pkg::ST_RSQ])
        begin
            rsq_reg  <= ppr_pkg::clamp32(64'(aa_reg) + 64'(bb_reg));
            aa_r_reg <= aa_reg;
            bb_r_reg <= bb_reg;
            ab_r_reg <= ab_reg;
            na_r_reg <= na_sq_reg;
            nb_r_reg <= nb_sq_reg;
            sd_rsq_reg <= sd_sq_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage: r^2, k1 r and the products of aa, bb, ab, r with the tangential lens terms
    // ------------------------------------------------------------------
    logic signed [31:0] rquad_reg, na_p_reg, nb_p_reg;
    logic signed [39:0] kr1_reg, e1_reg, e2_reg, e3_reg, f1_reg, f2_reg, f3_reg;
    ppr_pkg::side_t     sd_rpow_reg;

    always_ff @(posedge clk)
    begin
        if (en[ppr_pkg::ST_RPOW])
        begin
            rquad_reg <= ppr_pkg::clamp32(ppr_pkg::mulsh(rsq_reg, rsq_reg, 24));
            kr1_reg   <= 40'(ppr_pkg::mulsh(k1, rsq_reg, 24));
            e1_reg    <= 40'(ppr_pkg::mulsh(p1, ab_r_reg, 24));
            e2_reg    <= 40'(ppr_pkg::mulsh(p2, rsq_reg, 24));
            e3_reg    <= 40'(ppr_pkg::mulsh(p2, aa_r_reg, 24));
            f1_reg    <= 40'(ppr_pkg::mulsh(p2, ab_r_reg, 24));
            f2_reg    <= 40'(ppr_pkg::mulsh(p1, rsq_reg, 24));
            f3_reg    <= 40'(ppr_pkg::mulsh(p1, bb_r_reg, 24));
            na_p_reg  <= na_r_reg;
            nb_p_reg  <= nb_r_reg;
            sd_rpow_reg <= sd_rsq_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage: k2 r^2 and the tangential sums
    // ------------------------------------------------------------------
    logic signed [39:0] kr2_reg, kr1_s_reg;
    logic signed [42:0] ta_reg, tb_reg;
    logic signed [31:0] na_s_reg, nb_s_reg;
    ppr_pkg::side_t     sd_rsum_reg;

    always_ff @(posedge clk)
    begin
        if (en[ppr_pkg::ST_RSUM])
        begin
            kr2_reg   <= 40'(ppr_pkg::mulsh(k2, rquad_reg, 24));
            kr1_s_reg <= kr1_reg;
            ta_reg    <= 43'(e1_reg) * 43'sd2 + 43'(e2_reg) + 43'(e3_reg) * 43'sd2;
            tb_reg    <= 43'(f1_reg) * 43'sd2 + 43'(f2_reg) + 43'(f3_reg) * 43'sd2;
            na_s_reg  <= na_p_reg;
            nb_s_reg  <= nb_p_reg;
            sd_rsum_reg <= sd_rpow_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage: radial factor 1 + k1 r + k2 r^2 (Q4.28)
    // ------------------------------------------------------------------
    logic signed [31:0] rad_reg, na_d_reg, nb_d_reg;
    logic signed [42:0] ta_d_reg, tb_d_reg;
    ppr_pkg::side_t     sd_rad_reg;

    always_ff @(posedge clk)
    begin
        if (en[ppr_pkg::ST_RAD])
        begin
            rad_reg  <= ppr_pkg::clamp32(ppr_pkg::ONE_Q28 + 64'(kr1_s_reg) + 64'(kr2_reg));
            na_d_reg <= na_s_reg;
            nb_d_reg <= nb_s_reg;
            ta_d_reg <= ta_reg;
            tb_d_reg <= tb_reg;
            sd_rad_reg <= sd_rsum_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage: a*rad, b*rad
    // ------------------------------------------------------------------
    logic signed [35:0] sa_m_reg, sb_m_reg;
    logic signed [42:0] ta_m_reg, tb_m_reg;
    ppr_pkg::side_t     sd_scale_reg;

    always_ff @(posedge clk)
    begin
        if (en[ppr_pkg::ST_SCALE])
        begin
            sa_m_reg <= 36'(ppr_pkg::mulsh(na_d_reg, rad_reg, 28));
            sb_m_reg <= 36'(ppr_pkg::mulsh(nb_d_reg, rad_reg, 28));
            ta_m_reg <= ta_d_reg;
            tb_m_reg <= tb_d_reg;
            sd_scale_reg <= sd_rad_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage: distorted coordinates (Q4.28)
    // ------------------------------------------------------------------
    logic signed [31:0] da_reg, db_reg;
    ppr_pkg::side_t     sd_dist_reg;

    always_ff @(posedge clk)
    begin
        if (en[ppr_pkg::ST_DIST])
        begin
            da_reg <= ppr_pkg::clamp32(64'(sa_m_reg) + 64'(ta_m_reg));
            db_reg <= ppr_pkg::clamp32(64'(sb_m_reg) + 64'(tb_m_reg));
            sd_dist_reg <= sd_scale_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage: focal scaling and edge-direction products
    // ------------------------------------------------------------------
    logic signed [35:0] pu_reg, pv_reg, gxx_reg, gxy_reg, gyy_reg;
    ppr_pkg::side_t     sd_focal_reg;

    always_ff @(posedge clk)
    begin
        if (en[ppr_pkg::ST_FOCAL])
        begin
            pu_reg  <= 36'(ppr_pkg::mulsh(fx, da_reg, 28));
            pv_reg  <= 36'(ppr_pkg::mulsh(fy, db_reg, 28));
            gxx_reg <= 36'(ppr_pkg::mulsh(sd_dist_reg.dir_x, sd_dist_reg.dir_x, 30));
            gxy_reg <= 36'(ppr_pkg::mulsh(sd_dist_reg.dir_x, sd_dist_reg.dir_y, 30));
            gyy_reg <= 36'(ppr_pkg::mulsh(sd_dist_reg.dir_y, sd_dist_reg.dir_y, 30));
            sd_focal_reg <= sd_dist_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage: raw residual and projector I - d d^T
    // ------------------------------------------------------------------
    logic signed [31:0] eu_reg, ev_reg, g00_reg, g01_reg, g11_reg;
    logic               has_dir_reg;
    ppr_pkg::side_t     sd_res_reg;

    always_ff @(posedge clk)
    begin
        if (en[ppr_pkg::ST_RES])
        begin
            eu_reg  <= ppr_pkg::clamp32(64'(pu_reg) + 64'(cx) - 64'(sd_focal_reg.seen_u));
            ev_reg  <= ppr_pkg::clamp32(64'(pv_reg) + 64'(cy) - 64'(sd_focal_reg.seen_v));
            g00_reg <= ppr_pkg::clamp32(ppr_pkg::ONE_Q30 - 64'(gxx_reg));
            g01_reg <= ppr_pkg::clamp32(-64'(gxy_reg));
            g11_reg <= ppr_pkg::clamp32(ppr_pkg::ONE_Q30 - 64'(gyy_reg));
            has_dir_reg <= (sd_focal_reg.dir_x != 32'sd0) || (sd_focal_reg.dir_y != 32'sd0);
            sd_res_reg <= sd_focal_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage: projector products
    // ------------------------------------------------------------------
    logic signed [35:0] h00_reg, h01_reg, h10_reg, h11_reg;
    logic signed [31:0] eu_p_reg, ev_p_reg;
    logic               has_dir_p_reg;
    ppr_pkg::side_t     sd_proj_reg;

    always_ff @(posedge clk)
    begin
        if (en[ppr_pkg::ST_PROJ])
        begin
            h00_reg <= 36'(ppr_pkg::mulsh(g00_reg, eu_reg, 30));
            h01_reg <= 36'(ppr_pkg::mulsh(g01_reg, ev_reg, 30));
            h10_reg <= 36'(ppr_pkg::mulsh(g01_reg, eu_reg, 30));
            h11_reg <= 36'(ppr_pkg::mulsh(g11_reg, ev_reg, 30));
            eu_p_reg <= eu_reg;
            ev_p_reg <= ev_reg;
            has_dir_p_reg <= has_dir_reg;
            sd_proj_reg <= sd_res_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output register: select projected or raw residual, zero on bad depth
    // ------------------------------------------------------------------
    logic signed [31:0] ru_next, rv_next;
    logic signed [31:0] ru_reg, rv_reg;
    logic               bad_reg;

    always_comb
    begin
        if (sd_proj_reg.bad)
        begin
            ru_next = 32'sd0;
            rv_next = 32'sd0;
        end
        else if (has_dir_p_reg)
        begin
            ru_next = ppr_pkg::clamp32(64'(h00_reg) + 64'(h01_reg));
            rv_next = ppr_pkg::clamp32(64'(h10_reg) + 64'(h11_reg));
        end
        else
        begin
            ru_next = eu_p_reg;
            rv_next = ev_p_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ppr_pkg::ST_OUT])
        begin
            ru_reg  <= ru_next;
            rv_reg  <= rv_next;
            bad_reg <= sd_proj_reg.bad;
        end
    end

    assign resid_u   = ru_reg;
    assign resid_v   = rv_reg;
    assign depth_bad = bad_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `PPR_ASSERT_IMP(a_bad_zero, clk, rst_n, out_valid && depth_bad, resid_u == 32'sd0 && resid_v == 32'sd0, "bad depth beat carries non-zero residual")
    `PPR_ASSERT_NXT(a_accept_fill, clk, rst_n, in_valid && in_ready, v_reg[0], "accepted beat lost at pipe entry")
    `PPR_ASSERT_IMP(a_full_stall, clk, rst_n, !in_ready, &v_reg, "input stalled with an empty stage")

endmodule

`default_nettype wire
